[design/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: request modes, result
// status codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    // request modes
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // field widths fixed by the interface
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 5;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch the incoming item
        logic exec;     // apply the request to the ring
        logic load;     // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic count_ok;  // entry count within the store depth
    } t_sts;

endpackage

[design/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// Request sequencer: takes one item, runs it through the ring datapath and
// waits for the output register before taking the next item.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.load   = (r_state == S_LOAD) && i_sts.out_free;

endmodule

[design/dq_dpath.sv]
// ----------------------------------------------------------------------------
// dq_dpath
// Ring datapath: request latch, front pointer and entry count, the key
// store with a registered read, and the output register.
// ----------------------------------------------------------------------------
module dq_dpath
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [2:0]                 i_mode,
    input  logic signed [KEY_W-1:0]    i_key,
    input  logic                       i_out_ready,
    output t_sts                       o_sts,
    output logic                       o_out_valid,
    output logic signed [KEY_W-1:0]    o_out_key,
    output logic [1:0]                 o_out_status,
    output logic [COUNT_W-1:0]         o_out_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // latched request
    logic [2:0]                r_mode;
    logic signed [KEY_W-1:0]   r_key;

    // ring state
    logic [AW-1:0]             r_front;
    logic [AW-1:0]             n_front;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;

    // per-item result
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    logic                      r_pop_ok;
    logic                      n_pop_ok;

    // key store
    logic [KEY_W-1:0]          mem [DEPTH];
    logic [KEY_W-1:0]          r_rd_data;
    logic                      mem_we;
    logic                      mem_re;
    logic [AW-1:0]             mem_addr;

    // output register
    logic                      r_out_valid;
    logic signed [KEY_W-1:0]   r_out_key;
    logic [1:0]                r_out_status;
    logic [COUNT_W-1:0]        r_out_count;

    // ring arithmetic
    logic                      is_full;
    logic                      is_empty;
    logic [AW-1:0]             front_inc;
    logic [AW-1:0]             front_dec;
    logic [AW-1:0]             offset;
    logic [AW:0]               pos_sum;
    logic [AW-1:0]             back_pos;
    logic [CW+COUNT_W-1:0]     count_ext;

    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;

    // push back writes at front+count, pop back reads at front+count-1
    assign offset    = (r_mode == MODE_PUSH_BACK) ? r_count[AW-1:0]
                                                  : AW'(r_count - 1'b1);
    assign pos_sum   = {1'b0, r_front} + {1'b0, offset};
    assign back_pos  = (pos_sum >= (AW+1)'(DEPTH)) ? AW'(pos_sum - (AW+1)'(DEPTH))
                                                   : pos_sum[AW-1:0];

    // request decode
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_DONE;
        n_pop_ok = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_front;
        case (r_mode)
            MODE_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_front  = front_dec;
                    mem_addr = front_dec;
                    mem_we   = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_addr = back_pos;
                    mem_we   = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    mem_addr = r_front;
                    mem_re   = 1'b1;
                    n_pop_ok = 1'b1;
                    n_front  = front_inc;
                    n_count  = r_count - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    mem_addr = back_pos;
                    mem_re   = 1'b1;
                    n_pop_ok = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            MODE_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_key  <= i_key;
        end
    end

    // ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // per-item status
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // key store, single port with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            mem[mem_addr] <= r_key;
        end
        if (i_cmd.exec && mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // count as seen on the port, masked to its width
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_key    <= r_pop_ok ? $signed(r_rd_data) : '0;
            r_out_status <= r_status;
            r_out_count  <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.count_ok = (r_count <= CW'(DEPTH));
    assign o_out_valid    = r_out_valid;
    assign o_out_key      = r_out_key;
    assign o_out_status   = r_out_status;
    assign o_out_count    = r_out_count;

endmodule

[design/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit keys in a ring store of DEPTH
// entries. Each item is a request (push front, push back, pop front, pop back,
// clear) and yields exactly one result item with the popped key, a status and
// the entry count afterwards. One request is handled at a time: an item is
// accepted, then applied to the ring with the single store access, then its
// result is loaded, and the input is not ready for a new item until that
// load is done. The output register holds the result until it is taken, and
// the next item is held off until that register frees.
// A pop on an empty queue reports empty; a push on a full queue reports full
// and drops the key. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
// double_ended_queue
// Top level: request sequencer plus ring datapath.
// ----------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_mode,
    input  logic signed [KEY_W-1:0]  i_key_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [KEY_W-1:0]  o_key_out,
    output logic [1:0]               o_status,
    output logic [COUNT_W-1:0]       o_count
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // ring datapath
    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_key        (i_key_in),
        .i_out_ready  (i_out_ready),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_out_key    (o_key_out),
        .o_out_status (o_status),
        .o_out_count  (o_count)
    );

`ifndef ASSERT_OFF
    // one item in flight: taking an item drops ready on the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in flight");

    // entry count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.count_ok)
        else $error("entry count above depth");

    // failed requests return a zero key
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY || o_status == ST_FULL))
            |-> (o_key_out == '0))
        else $error("nonzero key on failed request");

    // reserved status code never shows
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3))
        else $error("reserved status code");
`endif

endmodule
